// ===== design/station_stop_assist_macros.svh =====
// Assertion macros shared by the station stop supervisor modules.
`ifndef STATION_STOP_ASSIST_MACROS_SVH
`define STATION_STOP_ASSIST_MACROS_SVH

`ifndef SYNTHESIS
`define SSA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("station stop assist: implication check failed");
`define SSA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("station stop assist: next-cycle check failed");
`else
`define SSA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SSA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/ssa_pkg.sv =====
// Types, constants and register map of the station stop supervisor.
package ssa_pkg;

    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int VAL_W     = 20;
    localparam int TIME_W    = 31;
    localparam int LOC_W     = 32;
    localparam int NOTCH_W   = 4;
    localparam int LOOP_W    = 16;
    localparam int STN_W     = 7;
    localparam int CLS_W     = 4;
    localparam int MASK_W    = 14;
    localparam int END_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRAKE_NOTCHES = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BUZZ_LOOP_MS  = 2'd2;

    localparam logic               ENABLE_RST        = 1'b1;
    localparam logic [NOTCH_W-1:0] BRAKE_NOTCHES_RST = 4'd8;
    localparam logic [LOOP_W-1:0]  BUZZ_LOOP_MS_RST  = 16'd1000;
    localparam logic signed [LOC_W-1:0] STOP_LOC_RST = -32'sd100;

    // value/100 = (value * 671089) >> 26, exact for 20-bit values
    localparam logic [19:0] RECIP_100    = 20'd671089;
    localparam int          RECIP_100_SH = 26;
    // value/100000 = (value * 1374390) >> 37, exact for 20-bit values
    localparam logic [20:0] RECIP_1E5    = 21'd1374390;
    localparam int          RECIP_1E5_SH = 37;
    localparam logic [CLS_W-1:0] CLASS_WRAP = 4'd10;

    localparam logic [END_W-1:0] BUZZ_STALE_MS = 32'd10000;

    typedef enum logic [1:0] {
        CMD_SET_ID  = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic               enable;
        logic [NOTCH_W-1:0] brake_notches;
        logic [LOOP_W-1:0]  buzz_loop_ms;
    } cfg_t;

    typedef struct packed {
        cmd_t                     command;
        logic [VAL_W-1:0]         beacon_value;
        logic [TIME_W-1:0]        time_ms;
        logic                     moving;
        logic signed [LOC_W-1:0]  location_cm;
        logic [NOTCH_W-1:0]       brake_position;
    } item_t;

    typedef struct packed {
        logic [STN_W-1:0]  station;
        logic [CLS_W-1:0]  class_digit;
        logic [MASK_W-1:0] mask;
    } dec_t;

endpackage

// ===== design/ssa_cfg.sv =====
// Configuration register file behind the APB-style port.
module ssa_cfg
    import ssa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:        cfg_next.enable        = pwdata[0];
                REG_BRAKE_NOTCHES: cfg_next.brake_notches = pwdata[NOTCH_W-1:0];
                REG_BUZZ_LOOP_MS:  cfg_next.buzz_loop_ms  = pwdata[LOOP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:        prdata = {31'd0, cfg_reg.enable};
            REG_BRAKE_NOTCHES: prdata = {{(32-NOTCH_W){1'b0}}, cfg_reg.brake_notches};
            REG_BUZZ_LOOP_MS:  prdata = {{(32-LOOP_W){1'b0}}, cfg_reg.buzz_loop_ms};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= ENABLE_RST;
            cfg_reg.brake_notches <= BRAKE_NOTCHES_RST;
            cfg_reg.buzz_loop_ms  <= BUZZ_LOOP_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/ssa_decode.sv =====
// Decimal split of a beacon code: station, class digit and class mask.
module ssa_decode
    import ssa_pkg::*;
(
    input  logic [VAL_W-1:0] beacon_value,
    output dec_t             dec
);

    logic [39:0]       prod_q;
    logic [40:0]       prod_c;
    logic [MASK_W-1:0] quot;
    logic [20:0]       quot_x100;
    logic [VAL_W-1:0]  rem;
    logic [CLS_W-1:0]  cls;

    // reciprocal multiplies stand in for the constant divides
    assign prod_q    = 40'(beacon_value) * 40'(RECIP_100);
    assign quot      = prod_q[RECIP_100_SH +: MASK_W];
    assign quot_x100 = {quot, 6'd0} + {1'b0, quot, 5'd0} + {5'd0, quot, 2'd0};
    assign rem       = beacon_value - quot_x100[VAL_W-1:0];

    assign prod_c    = 41'(beacon_value) * 41'(RECIP_1E5);
    assign cls       = prod_c[RECIP_1E5_SH +: CLS_W];

    assign dec.station     = rem[STN_W-1:0];
    // a leading digit pair of ten folds to class zero
    assign dec.class_digit = (cls == CLASS_WRAP) ? '0 : cls;
    assign dec.mask        = quot;

endmodule

// ===== design/ssa_core.sv =====
// Supervisor state and the result register; one item retires per cycle while out_stall does not hold the result.
module ssa_core
    import ssa_pkg::*;
`include "station_stop_assist_macros.svh"
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  item_t                   item,
    input  dec_t                    dec,
    input  cfg_t                    cfg,
    output logic                    res_ready,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    limit_valid,
    output logic [VAL_W-1:0]        limit_value,
    output logic                    stop_released,
    output logic                    buzzer_on,
    output logic                    stop_armed,
    output logic signed [LOC_W-1:0] stop_location_cm
);

    logic [CLS_W-1:0]        class_digit_reg, class_digit_next;
    logic [STN_W-1:0]        cur_station_reg, cur_station_next;
    logic [STN_W-1:0]        target_station_reg, target_station_next;
    logic                    armed_reg, armed_next;
    logic signed [LOC_W-1:0] stop_loc_reg, stop_loc_next;
    logic [END_W-1:0]        buzz_end_reg, buzz_end_next;
    logic                    buzz_active_reg, buzz_active_next;
    logic                    out_valid_reg;

    logic                    lim_ok_reg, lim_ok_next;
    logic [VAL_W-1:0]        lim_reg, lim_next;
    logic                    released_reg, released_next;
    logic                    res_buzz_reg;
    logic                    res_armed_reg;
    logic signed [LOC_W-1:0] res_loc_reg;

    logic                    fire;
    logic                    stop_fire;
    logic [LOOP_W+1:0]       loop_x3;
    logic [END_W-1:0]        now;

    assign res_ready = !out_valid_reg || !out_stall;
    assign fire      = item_valid && res_ready;
    assign stop_fire = fire && cfg.enable && (item.command == CMD_STOP);
    assign loop_x3   = {1'b0, cfg.buzz_loop_ms, 1'b0} + {2'b00, cfg.buzz_loop_ms};
    assign now       = {1'b0, item.time_ms};

    always_comb
    begin
        class_digit_next    = class_digit_reg;
        cur_station_next    = cur_station_reg;
        target_station_next = target_station_reg;
        armed_next          = armed_reg;
        stop_loc_next       = stop_loc_reg;
        buzz_end_next       = buzz_end_reg;
        buzz_active_next    = buzz_active_reg;
        lim_ok_next         = 1'b0;
        lim_next            = '0;
        released_next       = 1'b0;
        if (fire && cfg.enable)
        begin
            unique case (item.command)
                CMD_SET_ID:
                begin
                    cur_station_next = dec.station;
                    class_digit_next = dec.class_digit;
                end
                CMD_STOP:
                begin
                    if (item.moving && dec.mask[class_digit_reg])
                    begin
                        target_station_next = dec.station;
                        armed_next          = 1'b1;
                        buzz_end_next       = now + END_W'(loop_x3);
                        buzz_active_next    = 1'b1;
                    end
                end
                CMD_PATTERN:
                begin
                    if (armed_reg)
                    begin
                        stop_loc_next = item.location_cm;
                        lim_ok_next   = 1'b1;
                        lim_next      = item.beacon_value;
                    end
                end
                CMD_TICK:
                begin
                    if (!item.moving && (item.brake_position >= cfg.brake_notches) &&
                        armed_reg && (target_station_reg == cur_station_reg))
                    begin
                        armed_next    = 1'b0;
                        released_next = 1'b1;
                    end
                    // expired, or end time implausibly far ahead
                    if ((buzz_end_reg < now) || ((now + BUZZ_STALE_MS) < buzz_end_reg))
                    begin
                        buzz_active_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_digit_reg    <= '0;
            cur_station_reg    <= '0;
            target_station_reg <= '0;
            armed_reg          <= 1'b0;
            stop_loc_reg       <= STOP_LOC_RST;
            buzz_end_reg       <= '0;
            buzz_active_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            class_digit_reg    <= class_digit_next;
            cur_station_reg    <= cur_station_next;
            target_station_reg <= target_station_next;
            armed_reg          <= armed_next;
            stop_loc_reg       <= stop_loc_next;
            buzz_end_reg       <= buzz_end_next;
            buzz_active_reg    <= buzz_active_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lim_ok_reg    <= lim_ok_next;
            lim_reg       <= lim_next;
            released_reg  <= released_next;
            res_buzz_reg  <= buzz_active_next;
            res_armed_reg <= armed_next;
            res_loc_reg   <= stop_loc_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign limit_valid      = lim_ok_reg;
    assign limit_value      = lim_reg;
    assign stop_released    = released_reg;
    assign buzzer_on        = res_buzz_reg;
    assign stop_armed       = res_armed_reg;
    assign stop_location_cm = res_loc_reg;

    `SSA_ASSERT_IMP(a_release_disarms, clk, rst_n, out_valid_reg && released_reg, !res_armed_reg)
    `SSA_ASSERT_IMP(a_limit_needs_arm, clk, rst_n, out_valid_reg && lim_ok_reg, res_armed_reg)
    `SSA_ASSERT_IMP(a_limit_zero, clk, rst_n, out_valid_reg && !lim_ok_reg, lim_reg == '0)
    `SSA_ASSERT_IMP(a_buzz_from_beacon, clk, rst_n, $rose(buzz_active_reg), $past(stop_fire))

endmodule

// ===== design/station_stop_assist.sv =====
// Top level of the station stop supervisor: input register, config port, core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | sink      | in_valid/in_stall  | command, beacon_value, time_ms, moving,
//           |           |                    | location_cm, brake_position
//   out     | source    | out_valid/out_stall| limit_valid, limit_value, stop_released,
//           |           |                    | buzzer_on, stop_armed, stop_location_cm
//   cfg     | APB slave | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One item per cycle while out_stall is low; each transfer in gives one transfer out
// (through the input register, then the state update into the result register).
// Reset clears both valid flags and loads supervisor state and config; data registers are not reset.
// out_stall holds the result register; the input register keeps one more item,
// and in_stall rises only when it is full and the result cannot move on.
module station_stop_assist
    import ssa_pkg::*;
`include "station_stop_assist_macros.svh"
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              command,
    input  logic [VAL_W-1:0]        beacon_value,
    input  logic [TIME_W-1:0]       time_ms,
    input  logic                    moving,
    input  logic signed [LOC_W-1:0] location_cm,
    input  logic [NOTCH_W-1:0]      brake_position,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    limit_valid,
    output logic [VAL_W-1:0]        limit_value,
    output logic                    stop_released,
    output logic                    buzzer_on,
    output logic                    stop_armed,
    output logic signed [LOC_W-1:0] stop_location_cm,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t  cfg;
    dec_t  dec;
    item_t item_reg;
    logic  in_valid_reg;
    logic  res_ready;
    logic  in_take;

    assign in_stall = in_valid_reg && !res_ready;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command        <= cmd_t'(command);
            item_reg.beacon_value   <= beacon_value;
            item_reg.time_ms        <= time_ms;
            item_reg.moving         <= moving;
            item_reg.location_cm    <= location_cm;
            item_reg.brake_position <= brake_position;
        end
    end

    ssa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssa_decode u_decode (
        .beacon_value (item_reg.beacon_value),
        .dec          (dec)
    );

    ssa_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (in_valid_reg),
        .item             (item_reg),
        .dec              (dec),
        .cfg              (cfg),
        .res_ready        (res_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .limit_valid      (limit_valid),
        .limit_value      (limit_value),
        .stop_released    (stop_released),
        .buzzer_on        (buzzer_on),
        .stop_armed       (stop_armed),
        .stop_location_cm (stop_location_cm)
    );

    `SSA_ASSERT_IMP(a_stall_holds_item, clk, rst_n, in_stall, in_valid_reg && out_valid)
    `SSA_ASSERT_NXT(a_take_loads, clk, rst_n, in_take, in_valid_reg)

endmodule

// ===== test/station_stop_assist_tb.sv =====
// Self-checking testbench for station_stop_assist: directed and random transfers.
module station_stop_assist_tb
    import ssa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATION_BASE   = 100;
    localparam int CLASS_BASE     = 100000;
    localparam int CLASS_RADIX    = 10;
    localparam int BUZZ_LOOPS     = 3;
    localparam int STALE_AHEAD_MS = 10000;
    localparam longint TIME_MAX   = 64'd2147483647;

    typedef struct packed {
        logic                    limit_valid;
        logic [VAL_W-1:0]        limit_value;
        logic                    stop_released;
        logic                    buzzer_on;
        logic                    stop_armed;
        logic signed [LOC_W-1:0] stop_location_cm;
    } stop_result_t;

    // Shadow of the supervisor state plus the queue of results still owed.
    class stop_ledger;
        bit                  en;
        bit [NOTCH_W-1:0]    notch;
        bit [LOOP_W-1:0]     loop_ms;
        int unsigned         cls;
        int unsigned         cur_stn;
        int unsigned         tgt_stn;
        bit                  armed;
        logic signed [31:0]  stop_loc;
        longint              buzz_end;
        bit                  buzz_on;
        stop_result_t        due_results[$];
        int                  errors;

        function new();
            en       = ENABLE_RST;
            notch    = BRAKE_NOTCHES_RST;
            loop_ms  = BUZZ_LOOP_MS_RST;
            cls      = 0;
            cur_stn  = 0;
            tgt_stn  = 0;
            armed    = 1'b0;
            stop_loc = STOP_LOC_RST;
            buzz_end = 0;
            buzz_on  = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ENABLE:        en = data[0];
                REG_BRAKE_NOTCHES: notch = data[NOTCH_W-1:0];
                REG_BUZZ_LOOP_MS:  loop_ms = data[LOOP_W-1:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return due_results.size();
        endfunction

        function void note_transfer(item_t it);
            int unsigned  v;
            longint       now;
            stop_result_t r;
            v   = it.beacon_value;
            now = it.time_ms;
            r   = '0;
            if (en) begin
                case (it.command)
                    CMD_SET_ID: begin
                        cur_stn = v % STATION_BASE;
                        cls     = (v / CLASS_BASE) % CLASS_RADIX;
                    end
                    CMD_STOP: begin
                        if (it.moving && (((v / STATION_BASE) >> cls) & 1)) begin
                            tgt_stn  = v % STATION_BASE;
                            armed    = 1'b1;
                            buzz_end = now + BUZZ_LOOPS * longint'(loop_ms);
                            buzz_on  = 1'b1;
                        end
                    end
                    CMD_PATTERN: begin
                        if (armed) begin
                            stop_loc      = it.location_cm;
                            r.limit_valid = 1'b1;
                            r.limit_value = VAL_W'(v);
                        end
                    end
                    default: begin
                        if (!it.moving && it.brake_position >= notch && armed &&
                            tgt_stn == cur_stn) begin
                            armed           = 1'b0;
                            r.stop_released = 1'b1;
                        end
                        // buzzer ends when expired or when its end lies implausibly far ahead
                        if (buzz_end < now || now < buzz_end - STALE_AHEAD_MS)
                            buzz_on = 1'b0;
                    end
                endcase
            end
            r.buzzer_on        = buzz_on;
            r.stop_armed       = armed;
            r.stop_location_cm = stop_loc;
            due_results.push_back(r);
        endfunction

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
        endtask

        task check_transfer(stop_result_t got);
            stop_result_t want;
            if (due_results.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            want = due_results.pop_front();
            cmp_field("limit_valid", got.limit_valid, want.limit_valid);
            cmp_field("limit_value", got.limit_value, want.limit_value);
            cmp_field("stop_released", got.stop_released, want.stop_released);
            cmp_field("buzzer_on", got.buzzer_on, want.buzzer_on);
            cmp_field("stop_armed", got.stop_armed, want.stop_armed);
            cmp_field("stop_location_cm", got.stop_location_cm, want.stop_location_cm);
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              command;
    logic [VAL_W-1:0]        beacon_value;
    logic [TIME_W-1:0]       time_ms;
    logic                    moving;
    logic signed [LOC_W-1:0] location_cm;
    logic [NOTCH_W-1:0]      brake_position;
    logic                    out_valid;
    logic                    out_stall;
    logic                    limit_valid;
    logic [VAL_W-1:0]        limit_value;
    logic                    stop_released;
    logic                    buzzer_on;
    logic                    stop_armed;
    logic signed [LOC_W-1:0] stop_location_cm;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    stop_ledger ledger = new();

    int     send_idle_pct = 0;
    int     stall_pct = 0;
    longint gen_now = 0;
    int     gen_cls = 0;
    int     gen_stn = 0;

    station_stop_assist uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .beacon_value     (beacon_value),
        .time_ms          (time_ms),
        .moving           (moving),
        .location_cm      (location_cm),
        .brake_position   (brake_position),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .limit_valid      (limit_valid),
        .limit_value      (limit_value),
        .stop_released    (stop_released),
        .buzzer_on        (buzzer_on),
        .stop_armed       (stop_armed),
        .stop_location_cm (stop_location_cm),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk) begin : watch_results
        stop_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.limit_valid      = limit_valid;
            got.limit_value      = limit_value;
            got.stop_released    = stop_released;
            got.buzzer_on        = buzzer_on;
            got.stop_armed       = stop_armed;
            got.stop_location_cm = stop_location_cm;
            ledger.check_transfer(got);
        end
    end

    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= it.command;
        beacon_value   <= it.beacon_value;
        time_ms        <= it.time_ms;
        moving         <= it.moving;
        location_cm    <= it.location_cm;
        brake_position <= it.brake_position;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.note_transfer(it);
    endtask

    task automatic send_fields(input cmd_t c, input int unsigned v, input int unsigned t,
                               input bit mov, input logic [31:0] loc, input int unsigned brk);
        item_t it;
        it.command        = c;
        it.beacon_value   = VAL_W'(v);
        it.time_ms        = TIME_W'(t);
        it.moving         = mov;
        it.location_cm    = loc;
        it.brake_position = NOTCH_W'(brk);
        send_item(it);
    endtask

    // Hold the sender until every owed result has come back, then leave a short gap.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ledger.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input bit en, input int unsigned notch, input int unsigned loop_ms);
        reg_write(REG_ENABLE, {31'd0, en});
        reg_write(REG_BRAKE_NOTCHES, notch);
        reg_write(REG_BUZZ_LOOP_MS, loop_ms);
    endtask

    task automatic advance_clock_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      gen_now += $urandom_range(0, 1500);
        else if (r < 75) gen_now += $urandom_range(0, 30000);
        else if (r < 85) gen_now -= $urandom_range(0, 30000);
        else if (r < 90) gen_now = $urandom & 32'h7fffffff;
        else if (r < 93) gen_now = TIME_MAX - $urandom_range(0, 5000);
        if (gen_now < 0) gen_now = 0;
        if (gen_now > TIME_MAX) gen_now = TIME_MAX;
    endtask

    // Mostly coherent trips (id, stop beacon, pattern, ticks) with some pure noise.
    task automatic random_item(output item_t it);
        int          r;
        int unsigned mask;
        int unsigned stn;
        advance_clock_ms();
        it.command        = CMD_TICK;
        it.beacon_value   = VAL_W'($urandom_range(0, 999999));
        it.time_ms        = TIME_W'(gen_now);
        it.moving         = 1'($urandom_range(0, 1));
        it.location_cm    = $urandom;
        it.brake_position = NOTCH_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 15) begin
            it.command      = cmd_t'($urandom_range(0, 3));
            it.beacon_value = VAL_W'($urandom);
            it.time_ms      = TIME_W'($urandom);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
            it.command = CMD_SET_ID;
            gen_cls    = $urandom_range(0, 10);
            gen_stn    = $urandom_range(0, 99);
            // class ten only fits the 20-bit field with a small middle part
            if (gen_cls == 10)
                it.beacon_value = VAL_W'(1000000 + $urandom_range(0, 484) * 100 + gen_stn);
            else
                it.beacon_value = VAL_W'(gen_cls * CLASS_BASE +
                                         $urandom_range(0, 999) * 100 + gen_stn);
        end else if (r < 32) begin
            it.command = CMD_STOP;
            it.moving  = ($urandom_range(0, 7) != 0);
            mask       = $urandom_range(0, 9999);
            if ($urandom_range(0, 4) != 0)
                mask |= 1 << (gen_cls % CLASS_RADIX);
            stn        = ($urandom_range(0, 4) != 0) ? gen_stn : $urandom_range(0, 99);
            it.beacon_value = VAL_W'(mask * STATION_BASE + stn);
        end else if (r < 55) begin
            it.command = CMD_PATTERN;
            if ($urandom_range(0, 3) == 0)
                it.beacon_value = VAL_W'($urandom);
        end else begin
            it.command = CMD_TICK;
            it.moving  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) != 0)
                it.brake_position = NOTCH_W'(15 - $urandom_range(0, 3));
        end
    endtask

    initial begin
        item_t it;
        int    n;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= CMD_SET_ID;
        beacon_value   <= '0;
        time_ms        <= '0;
        moving         <= 1'b0;
        location_cm    <= '0;
        brake_position <= '0;
        out_stall      <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset configuration
        send_fields(CMD_TICK, 0, 0, 1'b0, 32'h0, 15);                // tick straight after reset
        send_fields(CMD_PATTERN, 999999, 0, 1'b1, 32'hffffffff, 0);  // nothing armed
        send_fields(CMD_SET_ID, 0, 10, 1'b0, 32'h0, 0);
        send_fields(CMD_STOP, 105, 20, 1'b0, 32'h0, 0);              // standing train
        send_fields(CMD_STOP, 205, 30, 1'b1, 32'h0, 0);              // class bit clear
        send_fields(CMD_SET_ID, 1048575, 40, 1'b1, 32'h0, 0);        // class ten wraps to zero
        send_fields(CMD_STOP, 175, 1000, 1'b1, 32'h0, 0);            // arms station 75
        send_fields(CMD_PATTERN, 999999, 1100, 1'b1, 32'h80000000, 0);
        send_fields(CMD_PATTERN, 0, 1200, 1'b1, 32'h7fffffff, 0);
        send_fields(CMD_TICK, 0, 2000, 1'b1, 32'h0, 15);             // still moving
        send_fields(CMD_TICK, 0, 3000, 1'b0, 32'h0, 7);              // brake short of full
        send_fields(CMD_TICK, 0, 4000, 1'b0, 32'h0, 8);              // release at buzzer end
        send_fields(CMD_TICK, 0, 4001, 1'b0, 32'h0, 8);              // buzzer expired
        send_fields(CMD_SET_ID, 912345, 5000, 1'b0, 32'h0, 0);
        send_fields(CMD_STOP, 999945, 2147483647, 1'b1, 32'h0, 0);   // end time past 31 bits
        send_fields(CMD_TICK, 0, 2147483647, 1'b0, 32'h0, 0);
        send_fields(CMD_STOP, 999945, 50000, 1'b1, 32'h0, 0);
        send_fields(CMD_TICK, 0, 30000, 1'b0, 32'h0, 15);            // end too far ahead
        send_fields(CMD_PATTERN, 524288, 30001, 1'b0, 32'h12345678, 3);
        drain();
        reg_write(REG_ENABLE, 0);
        send_fields(CMD_SET_ID, 123456, 100, 1'b0, 32'h0, 0);
        send_fields(CMD_STOP, 999945, 200, 1'b1, 32'h0, 0);
        send_fields(CMD_PATTERN, 777, 300, 1'b1, 32'h1, 0);
        send_fields(CMD_TICK, 0, 400, 1'b0, 32'h0, 15);

        for (int p = 0; p < 8; p++) begin
            drain();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            case (p)
                0: configure(1'b1, 8, 1000);
                1: configure(1'b1, 1, 0);
                2: configure(1'b1, 15, 65535);
                5: configure(1'b1, 15, 0);
                6: configure(1'b0, $urandom_range(1, 15), $urandom_range(0, 65535));
                default: configure(1'b1, $urandom_range(1, 15), $urandom_range(0, 65535));
            endcase
            n = (p == 6) ? 30 : 215;
            repeat (n) begin
                random_item(it);
                send_item(it);
                if ($urandom_range(0, 299) == 0)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (ledger.pending() != 0)
            ledger.report("results still outstanding at end of run");
        if (ledger.errors == 0)
            $display("station_stop_assist_tb OK");
        else
            $display("station_stop_assist_tb NOT OK");
        $finish;
    end

    initial begin
        #6000000;
        $display("station_stop_assist_tb NOT OK");
        $finish;
    end

endmodule
